### hdl/tvtm_pkg.sv
// Shared types, codes and helper functions of the texture view tone map block.
package tvtm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_GATHER  = 2'd1;
  localparam logic [1:0] MODE_CONVERT = 2'd2;

  localparam logic [1:0] REG_NORMALIZE = 2'd0;
  localparam logic [1:0] REG_CHANNEL   = 2'd1;
  localparam logic [1:0] REG_GAIN      = 2'd2;

  localparam logic [2:0] CH_RGB   = 3'd0;
  localparam logic [2:0] CH_RED   = 3'd1;
  localparam logic [2:0] CH_GREEN = 3'd2;
  localparam logic [2:0] CH_BLUE  = 3'd3;
  localparam logic [2:0] CH_ALPHA = 3'd4;
  localparam logic [2:0] CH_LUMA  = 3'd5;

  localparam logic [31:0] GAIN_RESET = 32'h0001_0000;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [15:0] LUMA_COEF [3] = '{16'd19595, 16'd38470, 16'd7471};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       stretch;
    logic [7:0] minimum;
    logic [7:0] span;
  } conv_entry_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_LUMA,
    ST_PACK
  } back_state_t;

  function automatic logic [7:0] to_byte(input logic signed [33:0] v);
    logic [7:0] res;
    if (v[33]) begin
      res = 8'd0;
    end else if (|v[32:24]) begin
      res = 8'hFF;
    end else begin
      res = v[23:16];
    end
    return res;
  endfunction

endpackage

### hdl/tvtm_front.sv
// Front end: accepts words, keeps the red statistics and queues convert words.
module tvtm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_mode,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic [7:0]           in_alpha,
  input  logic                 normalize_enable,
  output logic                 push_valid,
  input  logic                 push_ready,
  output tvtm_pkg::conv_entry_t push_data
);
  import tvtm_pkg::*;

  logic [7:0] red_min_r, red_min_nxt;
  logic [7:0] red_max_r, red_max_nxt;
  logic       accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    red_min_nxt = red_min_r;
    red_max_nxt = red_max_r;
    if (accept) begin
      case (in_mode)
        MODE_CLEAR: begin
          red_min_nxt = 8'hFF;
          red_max_nxt = 8'h00;
        end
        MODE_GATHER: begin
          if (in_red < red_min_r) red_min_nxt = in_red;
          if (in_red > red_max_r) red_max_nxt = in_red;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_min_r <= 8'hFF;
      red_max_r <= 8'h00;
    end else begin
      red_min_r <= red_min_nxt;
      red_max_r <= red_max_nxt;
    end
  end

  assign push_valid        = in_valid && (in_mode == MODE_CONVERT);
  assign push_data.red     = in_red;
  assign push_data.green   = in_green;
  assign push_data.blue    = in_blue;
  assign push_data.alpha   = in_alpha;
  assign push_data.stretch = normalize_enable && (red_max_r > red_min_r);
  assign push_data.minimum = red_min_r;
  assign push_data.span    = red_max_r - red_min_r;

endmodule

### hdl/tvtm_fifo.sv
// Short queue of convert words between the front and back ends.
module tvtm_fifo #(
  parameter int unsigned DEPTH = tvtm_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  tvtm_pkg::conv_entry_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output tvtm_pkg::conv_entry_t pop_data
);
  import tvtm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  conv_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hdl/tvtm_div.sv
// One lane of the bit-serial floor divider for the normalization stretch.
module tvtm_div (
  input  logic                      clk,
  input  tvtm_pkg::div_ctrl_t       ctrl,
  input  logic signed [8:0]         diff,
  input  logic [7:0]                span,
  output logic signed [32:0]        result
);
  import tvtm_pkg::*;

  logic [31:0] dq_r, dq_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  span_r;
  logic        neg_r;
  logic [8:0]  mag;
  logic [15:0] scaled;
  logic [8:0]  rem_sh;
  logic        fit;

  assign mag    = diff[8] ? 9'(-diff) : diff;
  assign scaled = {mag[7:0], 8'd0} - {8'd0, mag[7:0]};

  assign rem_sh = {rem_r, dq_r[31]};
  assign fit    = (rem_sh >= {1'b0, span_r});

  always_comb begin
    dq_nxt  = {dq_r[30:0], fit};
    rem_nxt = fit ? 8'(rem_sh - {1'b0, span_r}) : rem_sh[7:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dq_r   <= {scaled, 16'd0};
      rem_r  <= 8'd0;
      span_r <= span;
      neg_r  <= diff[8];
    end else if (ctrl.step) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign result = neg_r ? -$signed({1'b0, dq_r} + {32'd0, |rem_r})
                        : $signed({1'b0, dq_r});

endmodule

### hdl/tvtm_back.sv
// Back end: stretch, exposure gain, channel selection and the output register.
module tvtm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  tvtm_pkg::conv_entry_t q_data,
  input  logic [2:0]            channel_mode,
  input  logic [31:0]           exposure_gain,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_green,
  output logic [7:0]            out_red
);
  import tvtm_pkg::*;

  back_state_t state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  conv_entry_t          ent_r;
  div_ctrl_t            div_ctrl;
  logic                 pop;
  logic                 out_load;

  logic [7:0]          q_chan   [3];
  logic [7:0]          ent_chan [3];
  logic signed [32:0]  div_res  [3];
  logic signed [32:0]  v        [3];
  logic signed [49:0]  ph_r     [3];
  logic signed [49:0]  pl_r     [3];
  logic signed [49:0]  pl_sh    [3];
  logic signed [50:0]  s_full   [3];
  logic signed [30:0]  s_sat    [3];
  logic signed [30:0]  s_r      [3];
  logic signed [47:0]  m_r      [3];
  logic [7:0]          byte_c   [3];

  logic signed [49:0] lum_sum;
  logic signed [33:0] lum;
  logic [7:0]         byte_l;
  logic [7:0]         sel_r, sel_g, sel_b;
  logic [7:0]         out_red_r, out_green_r, out_blue_r;

  assign q_chan[0]   = q_data.red;
  assign q_chan[1]   = q_data.green;
  assign q_chan[2]   = q_data.blue;
  assign ent_chan[0] = ent_r.red;
  assign ent_chan[1] = ent_r.green;
  assign ent_chan[2] = ent_r.blue;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tvtm_div u_div (
      .clk    (clk),
      .ctrl   (div_ctrl),
      .diff   ($signed({1'b0, q_chan[i]}) - $signed({1'b0, q_data.minimum})),
      .span   (q_data.span),
      .result (div_res[i])
    );

    assign v[i] = ent_r.stretch ? div_res[i] : $signed({9'd0, ent_chan[i], 16'd0});

    assign pl_sh[i]  = pl_r[i] >>> 16;
    assign s_full[i] = $signed({ph_r[i][49], ph_r[i]}) + $signed({pl_sh[i][49], pl_sh[i]});
    assign s_sat[i]  = (&s_full[i][50:30] || ~|s_full[i][50:30]) ? s_full[i][30:0]
                     : (s_full[i][50] ? 31'sh4000_0000 : 31'sh3FFF_FFFF);
    assign byte_c[i] = to_byte(34'(s_r[i]));

    always_ff @(posedge clk) begin
      if (state_r == ST_MUL) begin
        ph_r[i] <= v[i] * $signed({1'b0, exposure_gain[31:16]});
        pl_r[i] <= v[i] * $signed({1'b0, exposure_gain[15:0]});
      end
      if (state_r == ST_SUM) begin
        s_r[i] <= s_sat[i];
      end
      if (state_r == ST_LUMA) begin
        m_r[i] <= s_r[i] * $signed({1'b0, LUMA_COEF[i]});
      end
    end
  end

  assign lum_sum = 50'(m_r[0]) + 50'(m_r[1]) + 50'(m_r[2]);
  assign lum     = 34'(lum_sum >>> 16);
  assign byte_l  = to_byte(lum);

  always_comb begin
    case (channel_mode)
      CH_RGB: begin
        sel_r = byte_c[0];
        sel_g = byte_c[1];
        sel_b = byte_c[2];
      end
      CH_RED: begin
        sel_r = byte_c[0];
        sel_g = byte_c[0];
        sel_b = byte_c[0];
      end
      CH_GREEN: begin
        sel_r = byte_c[1];
        sel_g = byte_c[1];
        sel_b = byte_c[1];
      end
      CH_BLUE: begin
        sel_r = byte_c[2];
        sel_g = byte_c[2];
        sel_b = byte_c[2];
      end
      CH_ALPHA: begin
        sel_r = ent_r.alpha;
        sel_g = ent_r.alpha;
        sel_b = ent_r.alpha;
      end
      CH_LUMA: begin
        sel_r = byte_l;
        sel_g = byte_l;
        sel_b = byte_l;
      end
      default: begin
        sel_r = byte_c[0];
        sel_g = byte_c[1];
        sel_b = byte_c[2];
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) state_nxt = q_data.stretch ? ST_DIV : ST_MUL;
      end
      ST_DIV: begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_LUMA;
      ST_LUMA: state_nxt = ST_PACK;
      ST_PACK: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop           = (state_r == ST_IDLE) && q_valid;
    div_ctrl.load = pop;
    div_ctrl.step = (state_r == ST_DIV);
    out_load      = (state_r == ST_PACK) && (!out_valid_r || out_ready);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (pop) begin
      cnt_nxt = '0;
    end else if (div_ctrl.step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= q_data;
    end
    if (out_load) begin
      out_red_r   <= sel_r;
      out_green_r <= sel_g;
      out_blue_r  <= sel_b;
    end
  end

  assign q_ready   = pop;
  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

### hdl/texture_view_tone_map_unit.sv
// Top level of the texture view tone map block with its configuration registers.
//
// The input channel takes one word per pixel operation: clear and gather words
// update the red minimum and maximum and produce nothing, convert words
// produce one display word of red, green and blue bytes on the output channel.
// The configuration channel writes normalize enable, channel mode and exposure
// gain by index; it is always ready, and it is to be written only while the
// block is idle, which the block itself does not enforce. Clear and gather
// words are taken one per cycle while the queue has room. A convert word goes
// through the bit-serial divider when normalization stretches it, then the
// gain multiply, sum and luma multiply stages and the output register; the
// back end pops a new convert word only after the last result is loaded.
// Convert words wait in a two-entry queue, so the front keeps accepting while
// the back end works or the output register holds a result.
// When the receiver stalls, the result stays in the output register, the back
// end stops before loading the next result, and the queue then fills.
// Reset empties the queue, drops any pending result, sets the red minimum to
// 255 and maximum to 0, and loads the register defaults with a unit gain.
module texture_view_tone_map_unit #(
  parameter int unsigned QUEUE_DEPTH = tvtm_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_blue,
  output logic [7:0] out_green,
  output logic [7:0] out_red,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import tvtm_pkg::*;

  logic        normalize_r;
  logic [2:0]  channel_mode_r;
  logic [31:0] gain_r;

  logic        push_valid;
  logic        push_ready;
  conv_entry_t push_data;
  logic        pop_valid;
  logic        pop_ready;
  conv_entry_t pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normalize_r    <= 1'b0;
      channel_mode_r <= CH_RGB;
      gain_r         <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NORMALIZE: normalize_r    <= cfg_data[0];
        REG_CHANNEL:   channel_mode_r <= cfg_data[2:0];
        REG_GAIN:      gain_r         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tvtm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_alpha         (in_alpha),
    .normalize_enable (normalize_r),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_data        (push_data)
  );

  tvtm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tvtm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (pop_valid),
    .q_ready       (pop_ready),
    .q_data        (pop_data),
    .channel_mode  (channel_mode_r),
    .exposure_gain (gain_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red)
  );

endmodule

### verif/tb_texture_view_tone_map_unit.sv
// Self-checking testbench for the texture view tone map unit.
`timescale 1ns / 1ps

module tb_texture_view_tone_map_unit;
  import tvtm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [2:0] CH_SPARE = 3'd7;
  localparam longint Q_MAX = 64'sd1073741823;
  localparam longint Q_MIN = -64'sd1073741824;
  localparam longint LUMA_R = 19595;
  localparam longint LUMA_G = 38470;
  localparam longint LUMA_B = 7471;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int SCRIPT_LEN = 35;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 155;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } display_word_t;

  typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [1:0]    reg_idx;
    logic [31:0]   reg_val;
    logic [1:0]    mode;
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
    logic [7:0]    alpha;
    bit            typed;
    display_word_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_CLEAR;
  logic [7:0]  in_red = 8'd0;
  logic [7:0]  in_green = 8'd0;
  logic [7:0]  in_blue = 8'd0;
  logic [7:0]  in_alpha = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_NORMALIZE;
  logic [31:0] cfg_data = 32'd0;

  logic        norm_en = 1'b0;
  logic [2:0]  chan_sel = CH_RGB;
  logic [31:0] gain_q16 = GAIN_RESET;
  logic [7:0]  red_min = 8'd255;
  logic [7:0]  red_max = 8'd0;

  display_word_t pending_pixels[$];
  bit            row_typed = 1'b0;
  display_word_t row_want = '0;
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  bit            gaps_on = 1'b1;
  int unsigned   gap_odds = 4;

  script_row_t script [SCRIPT_LEN];

  texture_view_tone_map_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .in_alpha(in_alpha),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_blue(out_blue),
    .out_green(out_green),
    .out_red(out_red),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic longint clamp_q16(input longint v);
    if (v > Q_MAX) begin
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      return Q_MIN;
    end
    return v;
  endfunction

  function automatic longint exposed_level(input logic [7:0] c, input bit stretch);
    longint lvl;
    longint ghi;
    longint glo;
    if (stretch) begin
      lvl = floor_quot((longint'(c) - longint'(red_min)) * 255 * 65536,
                       longint'(red_max) - longint'(red_min));
    end else begin
      lvl = longint'(c) * 65536;
    end
    ghi = longint'(gain_q16[31:16]);
    glo = longint'(gain_q16[15:0]);
    return clamp_q16(lvl * ghi + floor_quot(lvl * glo, 65536));
  endfunction

  function automatic logic [7:0] byte_clamp(input longint v);
    longint w;
    if (v < 0) begin
      return 8'd0;
    end
    w = v / 65536;
    return (w > 255) ? 8'd255 : w[7:0];
  endfunction

  function automatic display_word_t predict_display(input logic [7:0] r, g, b, a);
    bit            stretch;
    longint        lr;
    longint        lg;
    longint        lb;
    longint        sr;
    longint        sg;
    longint        sb;
    display_word_t w;
    stretch = norm_en && (red_max > red_min);
    lr = exposed_level(r, stretch);
    lg = exposed_level(g, stretch);
    lb = exposed_level(b, stretch);
    sr = lr;
    sg = lg;
    sb = lb;
    case (chan_sel)
      CH_RED: begin
        sg = lr;
        sb = lr;
      end
      CH_GREEN: begin
        sr = lg;
        sb = lg;
      end
      CH_BLUE: begin
        sr = lb;
        sg = lb;
      end
      CH_ALPHA: begin
        sr = longint'(a) * 65536;
        sg = sr;
        sb = sr;
      end
      CH_LUMA: begin
        sr = floor_quot(LUMA_R * lr + LUMA_G * lg + LUMA_B * lb, 65536);
        sg = sr;
        sb = sr;
      end
      default: begin
      end
    endcase
    w.red = byte_clamp(sr);
    w.green = byte_clamp(sg);
    w.blue = byte_clamp(sb);
    return w;
  endfunction

  always @(posedge clk) begin
    display_word_t got;
    display_word_t ref_w;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NORMALIZE: norm_en = cfg_data[0];
          REG_CHANNEL: chan_sel = cfg_data[2:0];
          REG_GAIN: gain_q16 = cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{red: out_red, green: out_green, blue: out_blue};
        if (pending_pixels.size() == 0) begin
          $error("unexpected result word: red %0d green %0d blue %0d",
                 out_red, out_green, out_blue);
          mismatch_count++;
        end else begin
          ref_w = pending_pixels.pop_front();
          if (got.red !== ref_w.red) begin
            $error("out_red: expected %0d, got %0d", ref_w.red, got.red);
            mismatch_count++;
          end
          if (got.green !== ref_w.green) begin
            $error("out_green: expected %0d, got %0d", ref_w.green, got.green);
            mismatch_count++;
          end
          if (got.blue !== ref_w.blue) begin
            $error("out_blue: expected %0d, got %0d", ref_w.blue, got.blue);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_mode)
          MODE_CLEAR: begin
            red_min = 8'd255;
            red_max = 8'd0;
          end
          MODE_GATHER: begin
            if (in_red < red_min) begin
              red_min = in_red;
            end
            if (in_red > red_max) begin
              red_max = in_red;
            end
          end
          MODE_CONVERT: begin
            if (row_typed) begin
              pending_pixels.push_back(row_want);
            end else begin
              pending_pixels.push_back(predict_display(in_red, in_green, in_blue,
                                                       in_alpha));
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  function automatic script_row_t word_row(input logic [1:0] m, input logic [7:0] r, g, b, a);
    script_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.mode = m;
    row.red = r;
    row.green = g;
    row.blue = b;
    row.alpha = a;
    return row;
  endfunction

  function automatic script_row_t typed_row(input logic [7:0] r, g, b, a,
                                            input logic [7:0] wr, wg, wb);
    script_row_t row;
    row = word_row(MODE_CONVERT, r, g, b, a);
    row.typed = 1'b1;
    row.want = '{red: wr, green: wg, blue: wb};
    return row;
  endfunction

  function automatic script_row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
    script_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return GAIN_RESET;
      3: return $urandom_range(0, 32'h0004_0000);
      4: return $urandom_range(32'h0000_4000, 32'h0002_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input logic [1:0] m, input logic [7:0] r, g, b, a,
                           input bit typed, input display_word_t want);
    @(negedge clk);
    if (gaps_on && $urandom_range(1, gap_odds) == 1) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_mode = m;
    in_red = r;
    in_green = g;
    in_blue = b;
    in_alpha = a;
    row_typed = typed;
    row_want = want;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_random(input logic [1:0] m);
    push_word(m, rand_byte(), rand_byte(), rand_byte(), rand_byte(), 1'b0, '0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned done;
    int unsigned k;
    logic [1:0]  m;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) < 7) begin
          push_random(MODE_CLEAR);
          done++;
        end
        k = $urandom_range(0, 6);
        repeat (k) begin
          push_random(MODE_GATHER);
          done++;
        end
        k = $urandom_range(1, 12);
        repeat (k) begin
          push_random(MODE_CONVERT);
          done++;
        end
      end else begin
        m = 2'($urandom_range(0, 3));
        push_random(m);
        if (m != MODE_UNUSED) begin
          done++;
        end
      end
    end
  endtask

  initial begin
    script = '{
      typed_row(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0),
      typed_row(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255),
      typed_row(8'd18, 8'd129, 8'd66, 8'd200, 8'd18, 8'd129, 8'd66),
      word_row(MODE_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255),
      word_row(MODE_GATHER, 8'd40, 8'd0, 8'd0, 8'd0),
      word_row(MODE_GATHER, 8'd200, 8'd255, 8'd255, 8'd255),
      reg_row(REG_NORMALIZE, 32'd1),
      word_row(MODE_CONVERT, 8'd40, 8'd120, 8'd200, 8'd9),
      word_row(MODE_CONVERT, 8'd10, 8'd255, 8'd0, 8'd255),
      reg_row(REG_CHANNEL, {29'd0, CH_LUMA}),
      word_row(MODE_CONVERT, 8'd30, 8'd0, 8'd0, 8'd0),
      word_row(MODE_CONVERT, 8'd200, 8'd200, 8'd200, 8'd0),
      word_row(MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0),
      word_row(MODE_CONVERT, 8'd100, 8'd50, 8'd25, 8'd0),
      word_row(MODE_GATHER, 8'd77, 8'd0, 8'd0, 8'd0),
      word_row(MODE_CONVERT, 8'd77, 8'd77, 8'd77, 8'd0),
      reg_row(REG_CHANNEL, {29'd0, CH_ALPHA}),
      reg_row(REG_GAIN, 32'd0),
      typed_row(8'd1, 8'd2, 8'd3, 8'd171, 8'd171, 8'd171, 8'd171),
      reg_row(REG_CHANNEL, {29'd0, CH_SPARE}),
      reg_row(REG_GAIN, 32'hFFFF_FFFF),
      typed_row(8'd1, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0),
      reg_row(REG_UNUSED, 32'h5A5A_A5A5),
      typed_row(8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0),
      word_row(MODE_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255),
      word_row(MODE_GATHER, 8'd0, 8'd0, 8'd0, 8'd0),
      word_row(MODE_GATHER, 8'd255, 8'd0, 8'd0, 8'd0),
      reg_row(REG_GAIN, GAIN_RESET),
      reg_row(REG_CHANNEL, {29'd0, CH_RED}),
      word_row(MODE_CONVERT, 8'd128, 8'd0, 8'd0, 8'd0),
      reg_row(REG_CHANNEL, {29'd0, CH_GREEN}),
      word_row(MODE_CONVERT, 8'd0, 8'd64, 8'd0, 8'd0),
      reg_row(REG_CHANNEL, {29'd0, CH_BLUE}),
      reg_row(REG_NORMALIZE, 32'd0),
      word_row(MODE_CONVERT, 8'd0, 8'd0, 8'd99, 8'd0)
    };
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        push_word(script[i].mode, script[i].red, script[i].green, script[i].blue,
                  script[i].alpha, script[i].typed, script[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph >= PHASES - 2) begin
        gaps_on = 1'b0;
      end
      gap_odds = $urandom_range(2, 10);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, $urandom);
      end
      write_reg(REG_NORMALIZE, $urandom);
      write_reg(REG_CHANNEL, $urandom);
      write_reg(REG_GAIN, pick_gain());
      run_phase(PHASE_ITEMS);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
